// ----- rtl/ihex_pkg.sv -----
`default_nettype none

package ihex_pkg;

   localparam int CharWidth = 8;
   localparam int UpperWidth = 16;
   localparam int AddrWidth = 32;
   localparam int HalfWidth = 16;
   localparam int PosWidth = 10;

   localparam logic [UpperWidth-1:0] UpperAddrReset = 16'd2048;

   localparam logic [CharWidth-1:0] ColonChar = 8'd58;
   localparam logic [CharWidth-1:0] DigitLow = 8'd48;
   localparam logic [CharWidth-1:0] DigitHigh = 8'd57;
   // non-digit decode: (c - 55) mod 16 == c[3:0] + 9 mod 16
   localparam logic [3:0] LetterNibbleAdj = 4'd9;

   // character positions within a record, colon at position 0
   localparam logic [PosWidth-1:0] PosStart = 10'd1;
   localparam logic [PosWidth-1:0] PosByteCount = 10'd2;
   localparam logic [PosWidth-1:0] PosOffsetHigh = 10'd4;
   localparam logic [PosWidth-1:0] PosOffsetLow = 10'd6;
   localparam logic [PosWidth-1:0] PosType = 10'd8;
   localparam logic [PosWidth-1:0] PosData = 10'd10;

   localparam logic [3:0] DataTypeDigit = 4'd0;

   // result queue depth
   localparam int RspDepth = 3;

   typedef enum logic {
      RSP_WRITE = 1'b0,
      RSP_END   = 1'b1
   } rsp_kind_type;

   typedef struct packed {
      rsp_kind_type          kind;
      logic [AddrWidth-1:0]  addr;
      logic [HalfWidth-1:0]  half;
      logic                  checksum_ok;
      logic                  was_data;
   } rsp_word_type;

endpackage

`default_nettype wire

// ----- rtl/ihex_parse.sv -----
`default_nettype none

module ihex_parse (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [ihex_pkg::UpperWidth-1:0] csr_wr_data,
   input  wire logic                            char_valid,
   input  wire logic [ihex_pkg::CharWidth-1:0]  char_data,
   output logic                                 res_valid,
   output ihex_pkg::rsp_word_type               res_word
);
   import ihex_pkg::*;

   logic [UpperWidth-1:0] upper_ff, upper_in;
   logic [PosWidth-1:0]   pos_ff, pos_in;
   logic                  in_record_ff, in_record_in;
   logic [7:0]            count_ff, count_in;
   logic [15:0]           offset_ff, offset_in;
   logic [3:0]            type_ff, type_in;
   logic [3:0]            high_ff, high_in;
   logic [7:0]            low_ff, low_in;
   logic [7:0]            sum_ff, sum_in;
   logic [7:0]            pair_ff, pair_in;

   logic [3:0]            nib;
   logic [7:0]            byte_val;
   logic [7:0]            sum_next;
   logic [PosWidth-1:0]   pos_rel;
   logic [PosWidth-2:0]   data_idx;
   logic [AddrWidth-1:0]  write_addr;

   always_comb begin
      if (char_data >= DigitLow && char_data <= DigitHigh) begin
         nib = char_data[3:0];
      end else begin
         nib = char_data[3:0] + LetterNibbleAdj;
      end
      byte_val = {high_ff, nib};
      sum_next = sum_ff + byte_val;
      pos_rel = pos_ff - PosData;
      data_idx = pos_rel[PosWidth-1:1];
      write_addr = {upper_ff, offset_ff} + AddrWidth'({pair_ff, 1'b0});
   end

   always_comb begin
      upper_in = upper_ff;
      pos_in = pos_ff;
      in_record_in = in_record_ff;
      count_in = count_ff;
      offset_in = offset_ff;
      type_in = type_ff;
      high_in = high_ff;
      low_in = low_ff;
      sum_in = sum_ff;
      pair_in = pair_ff;
      res_valid = 1'b0;
      res_word = '0;

      if (csr_wr_en) begin
         upper_in = csr_wr_data;
      end

      if (char_valid) begin
         if (char_data == ColonChar) begin
            // restart, drop any partial record
            in_record_in = 1'b1;
            pos_in = PosStart;
            count_in = '0;
            offset_in = '0;
            type_in = '0;
            high_in = '0;
            low_in = '0;
            sum_in = '0;
            pair_in = '0;
         end else if (in_record_ff) begin
            pos_in = pos_ff + PosWidth'(1);
            if (pos_ff[0]) begin
               high_in = nib;
            end else begin
               sum_in = sum_next;
               if (pos_ff == PosByteCount) begin
                  count_in = byte_val;
               end else if (pos_ff == PosOffsetHigh) begin
                  offset_in = {byte_val, offset_ff[7:0]};
               end else if (pos_ff == PosOffsetLow) begin
                  offset_in = {offset_ff[15:8], byte_val};
               end else if (pos_ff == PosType) begin
                  type_in = nib;
               end else if (pos_ff >= PosData) begin
                  if (data_idx < {1'b0, count_ff}) begin
                     if (!data_idx[0]) begin
                        low_in = byte_val;
                     end else if (type_ff == DataTypeDigit) begin
                        pair_in = pair_ff + 8'd1;
                        res_valid = 1'b1;
                        res_word.kind = RSP_WRITE;
                        res_word.addr = write_addr;
                        res_word.half = {byte_val, low_ff};
                     end
                  end else begin
                     // checksum byte done: close the record
                     in_record_in = 1'b0;
                     pos_in = '0;
                     res_valid = 1'b1;
                     res_word.kind = RSP_END;
                     res_word.checksum_ok = (sum_next == 8'd0);
                     res_word.was_data = (type_ff == DataTypeDigit);
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff <= UpperAddrReset;
         pos_ff <= '0;
         in_record_ff <= 1'b0;
         count_ff <= '0;
         offset_ff <= '0;
         type_ff <= '0;
         high_ff <= '0;
         low_ff <= '0;
         sum_ff <= '0;
         pair_ff <= '0;
      end else begin
         upper_ff <= upper_in;
         pos_ff <= pos_in;
         in_record_ff <= in_record_in;
         count_ff <= count_in;
         offset_ff <= offset_in;
         type_ff <= type_in;
         high_ff <= high_in;
         low_ff <= low_in;
         sum_ff <= sum_in;
         pair_ff <= pair_in;
      end
   end

`ifndef ASSERT_OFF
   a_end_closes: assert property (@(posedge clock) disable iff (reset)
      res_valid && res_word.kind == RSP_END |=> !in_record_ff)
      else $error("record end left parser inside a record");

   a_result_needs_record: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> in_record_ff && char_valid && !pos_ff[0])
      else $error("result produced outside a record byte");
`endif

endmodule

`default_nettype wire

// ----- rtl/ihex_rsp_fifo.sv -----
`default_nettype none

module ihex_rsp_fifo (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            push,
   input  wire ihex_pkg::rsp_word_type          push_word,
   input  wire logic                            pop,
   output logic                                 head_valid,
   output ihex_pkg::rsp_word_type               head_word,
   output logic [$clog2(ihex_pkg::RspDepth+1)-1:0] count
);
   import ihex_pkg::*;

   localparam int PtrWidth = $clog2(RspDepth);
   localparam int CntWidth = $clog2(RspDepth + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(RspDepth - 1);

   rsp_word_type          entries_ff [RspDepth];
   logic [PtrWidth-1:0]   wptr_ff, wptr_in;
   logic [PtrWidth-1:0]   rptr_ff, rptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == LastPtr) ? '0 : wptr_ff + PtrWidth'(1);
      end
      if (pop) begin
         rptr_in = (rptr_ff == LastPtr) ? '0 : rptr_ff + PtrWidth'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CntWidth'(1);
         2'b01:   count_in = count_ff - CntWidth'(1);
         default: count_in = count_ff;
      endcase
   end

   assign head_valid = (count_ff != '0);
   assign head_word = entries_ff[rptr_ff];
   assign count = count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         count_ff <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff == CntWidth'(RspDepth) && !pop |-> !push)
      else $error("push into full result queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from empty result queue");
`endif

endmodule

`default_nettype wire

// ----- rtl/intel_hex_record_parser_top.sv -----
`default_nettype none

// Intel HEX record parser.
// Request channel: one ASCII character per word on req_ascii_char, taken at a
// rising edge with req_valid high and req_stall low. A ':' opens a record;
// byte count, offset, type, data and checksum follow as hex digit pairs.
// Response channel: one word per halfword flash write (rsp_result_kind 0,
// address and little-endian halfword) and one word at each record end
// (rsp_result_kind 1, checksum verdict and data-record flag). Data records
// with an odd byte count drop the last byte from the writes.
// Configuration: csr_wr_en/csr_wr_data load the upper 16 address bits;
// write it only while the block is idle.
// A taken character is held in the input register, then parsed; any response
// word it causes enters the queue and shows on rsp_ once it reaches the head.
// Throughput: one character per cycle, sustained as long as the receiver
// takes responses; the three-word result queue absorbs a stalled receiver.
// req_stall is a registered flag that rises once the queue plus the input
// register could not absorb another word.
// Reset: synchronous, active high; the parser leaves any record, the queue
// empties and the upper address returns to 0x0800.
module intel_hex_record_parser_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [ihex_pkg::UpperWidth-1:0] csr_wr_data,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [ihex_pkg::CharWidth-1:0]  req_ascii_char,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_result_kind,
   output logic [ihex_pkg::AddrWidth-1:0]       rsp_write_address,
   output logic [ihex_pkg::HalfWidth-1:0]       rsp_write_halfword,
   output logic                                 rsp_checksum_ok,
   output logic                                 rsp_was_data_record
);
   import ihex_pkg::*;

   localparam int CntWidth = $clog2(RspDepth + 1);
   // one extra bit so queue count plus the input register cannot wrap
   localparam int OccWidth = CntWidth + 1;

   // input register
   logic                  in_valid_ff, in_valid_in;
   logic [CharWidth-1:0]  in_char_ff;
   logic                  req_stall_ff, req_stall_in;

   logic                  accept;
   logic                  fire;
   logic                  res_valid;
   rsp_word_type          res_word;
   logic                  push;
   logic                  pop;
   logic                  head_valid;
   rsp_word_type          head_word;
   logic [CntWidth-1:0]   q_count;
   logic [OccWidth-1:0]   occ_next;

   assign accept = req_valid && !req_stall_ff;
   // advance the held character whenever the queue has a free slot
   assign fire = in_valid_ff && (q_count != CntWidth'(RspDepth));
   assign push = fire && res_valid;
   assign pop = head_valid && !rsp_stall;

   always_comb begin
      in_valid_in = accept || (in_valid_ff && !fire);
      // occupancy after this edge: queue words plus a held character
      occ_next = OccWidth'(q_count) + OccWidth'(push) - OccWidth'(pop)
               + OccWidth'(in_valid_in);
      // stall when one more word might not find room
      req_stall_in = (occ_next >= OccWidth'(RspDepth));
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_char_ff <= req_ascii_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         req_stall_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         req_stall_ff <= req_stall_in;
      end
   end

   ihex_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .char_valid  (fire),
      .char_data   (in_char_ff),
      .res_valid   (res_valid),
      .res_word    (res_word)
   );

   ihex_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_word  (res_word),
      .pop        (pop),
      .head_valid (head_valid),
      .head_word  (head_word),
      .count      (q_count)
   );

   assign req_stall = req_stall_ff;
   assign rsp_valid = head_valid;
   assign rsp_result_kind = head_word.kind;
   assign rsp_write_address = head_word.addr;
   assign rsp_write_halfword = head_word.half;
   assign rsp_checksum_ok = head_word.checksum_ok;
   assign rsp_was_data_record = head_word.was_data;

`ifndef ASSERT_OFF
   a_room_when_open: assert property (@(posedge clock) disable iff (reset)
      !req_stall_ff |-> OccWidth'(q_count) + OccWidth'(in_valid_ff) < OccWidth'(RspDepth))
      else $error("request side open without room for another word");

   a_held_advances: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff |-> fire)
      else $error("held character blocked by a full result queue");
`endif

endmodule

`default_nettype wire

// ----- sim/ihex_record_checker.sv -----
`default_nettype none

module ihex_record_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [ihex_pkg::UpperWidth-1:0] csr_wr_data,
   input  wire logic                            req_valid,
   input  wire logic                            req_stall,
   input  wire logic [ihex_pkg::CharWidth-1:0]  req_ascii_char,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   input  wire logic                            rsp_result_kind,
   input  wire logic [ihex_pkg::AddrWidth-1:0]  rsp_write_address,
   input  wire logic [ihex_pkg::HalfWidth-1:0]  rsp_write_halfword,
   input  wire logic                            rsp_checksum_ok,
   input  wire logic                            rsp_was_data_record,
   output int unsigned                          fail_count,
   output int unsigned                          open_count
);

   import ihex_pkg::*;

   localparam logic [CharWidth-1:0] LetterBias = 8'd55;
   localparam int MaxReports = 10;

   // parser state mirror
   logic [UpperWidth-1:0] upper_q;
   logic [PosWidth-1:0]   char_pos;
   logic                  in_rec;
   logic [7:0]            rec_count;
   logic [15:0]           rec_offset;
   logic [3:0]            rec_type;
   logic [3:0]            hi_nib;
   logic [7:0]            lo_byte;
   logic [7:0]            rec_sum;
   logic [7:0]            pair_idx;

   rsp_word_type expected_words[$];

   initial begin
      fail_count = 0;
   end

   function automatic logic [3:0] hex_value(input logic [CharWidth-1:0] c);
      logic [CharWidth-1:0] d;
      if (c >= DigitLow && c <= DigitHigh) begin
         d = c - DigitLow;
      end else begin
         d = c - LetterBias;
      end
      return d[3:0];
   endfunction

   task automatic clear_record();
      char_pos = '0;
      in_rec = 1'b0;
      rec_count = '0;
      rec_offset = '0;
      rec_type = '0;
      hi_nib = '0;
      lo_byte = '0;
      rec_sum = '0;
      pair_idx = '0;
   endtask

   // advance the parser by one character, queue any word it produces
   task automatic decode_char(input logic [CharWidth-1:0] c);
      logic [PosWidth-1:0] p;
      logic [PosWidth-1:0] j;
      logic [3:0]          nib;
      logic [7:0]          b;
      rsp_word_type        w;
      w = '0;
      if (c == ColonChar) begin
         clear_record();
         in_rec = 1'b1;
         char_pos = PosStart;
      end else if (in_rec) begin
         p = char_pos;
         char_pos = p + 1'b1;
         nib = hex_value(c);
         if (p[0]) begin
            hi_nib = nib;
         end else begin
            b = {hi_nib, nib};
            rec_sum = rec_sum + b;
            if (p == PosByteCount) begin
               rec_count = b;
            end else if (p == PosOffsetHigh) begin
               rec_offset[15:8] = b;
            end else if (p == PosOffsetLow) begin
               rec_offset[7:0] = b;
            end else if (p == PosType) begin
               rec_type = nib;
            end else if (p >= PosData) begin
               j = (p - PosData) >> 1;
               if (j < PosWidth'(rec_count)) begin
                  if (!j[0]) begin
                     lo_byte = b;
                  end else if (rec_type == DataTypeDigit) begin
                     w.kind = RSP_WRITE;
                     w.addr = {upper_q, rec_offset} + (32'(pair_idx) << 1);
                     w.half = {b, lo_byte};
                     pair_idx = pair_idx + 1'b1;
                     expected_words.push_back(w);
                  end
               end else begin
                  in_rec = 1'b0;
                  char_pos = '0;
                  w.kind = RSP_END;
                  w.checksum_ok = (rec_sum == 8'd0);
                  w.was_data = (rec_type == DataTypeDigit);
                  expected_words.push_back(w);
               end
            end
         end
      end
   endtask

   task automatic compare_word();
      rsp_word_type e;
      if (expected_words.size() == 0) begin
         fail_count++;
         if (fail_count <= MaxReports) begin
            $display("%0t: unexpected response word: kind %0d addr %h half %h ok %0d data %0d",
                     $time, rsp_result_kind, rsp_write_address, rsp_write_halfword,
                     rsp_checksum_ok, rsp_was_data_record);
         end
      end else begin
         e = expected_words.pop_front();
         if (rsp_result_kind !== e.kind || rsp_write_address !== e.addr ||
             rsp_write_halfword !== e.half || rsp_checksum_ok !== e.checksum_ok ||
             rsp_was_data_record !== e.was_data) begin
            fail_count++;
            if (fail_count <= MaxReports) begin
               $display("%0t: mismatch (exp/got): kind %0d/%0d addr %h/%h half %h/%h",
                        $time, e.kind, rsp_result_kind, e.addr, rsp_write_address,
                        e.half, rsp_write_halfword);
               $display("   checksum_ok %0d/%0d was_data_record %0d/%0d",
                        e.checksum_ok, rsp_checksum_ok, e.was_data, rsp_was_data_record);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_record();
         upper_q = UpperAddrReset;
         expected_words.delete();
      end else begin
         if (csr_wr_en) upper_q = csr_wr_data;
         if (req_valid && !req_stall) decode_char(req_ascii_char);
         if (rsp_valid && !rsp_stall) compare_word();
      end
      open_count <= expected_words.size();
   end

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`default_nettype none

module tb_top;

   import ihex_pkg::*;

   localparam logic [CharWidth-1:0] ChZero = "0";
   localparam logic [CharWidth-1:0] ChUpperA = "A";
   localparam logic [CharWidth-1:0] ChLowerA = "a";
   localparam logic [7:0] DataRecord = 8'h00;
   localparam logic [7:0] EofRecord = 8'h01;
   localparam int unsigned PhaseBudget = 200;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [UpperWidth-1:0] csr_wr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [CharWidth-1:0]  req_ascii_char = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_result_kind;
   logic [AddrWidth-1:0]  rsp_write_address;
   logic [HalfWidth-1:0]  rsp_write_halfword;
   logic                  rsp_checksum_ok;
   logic                  rsp_was_data_record;

   int unsigned chk_fails;
   int unsigned chk_open;

   // knobs the stimulus turns for the receiver process and the sender
   logic rsp_hold_ask = 1'b0;
   logic calm = 1'b0;

   int unsigned chars_sent = 0;
   logic [CharWidth-1:0] line_buf[$];
   logic [7:0] data_buf[$];

   always #4 clock = ~clock;

   intel_hex_record_parser_top dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_ascii_char     (req_ascii_char),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_write_address  (rsp_write_address),
      .rsp_write_halfword (rsp_write_halfword),
      .rsp_checksum_ok    (rsp_checksum_ok),
      .rsp_was_data_record(rsp_was_data_record)
   );

   ihex_record_checker chk (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_ascii_char     (req_ascii_char),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_write_address  (rsp_write_address),
      .rsp_write_halfword (rsp_write_halfword),
      .rsp_checksum_ok    (rsp_checksum_ok),
      .rsp_was_data_record(rsp_was_data_record),
      .fail_count         (chk_fails),
      .open_count         (chk_open)
   );

   // Offer one character word and hold it until taken, then maybe idle.
   // Valid stays high across back-to-back words; it only drops for a gap.
   task automatic push_char(input logic [CharWidth-1:0] c);
      int unsigned r;
      int unsigned gap;
      req_valid <= 1'b1;
      req_ascii_char <= c;
      do @(posedge clock); while (req_stall);
      chars_sent++;
      gap = 0;
      if (!calm) begin
         r = $urandom_range(0, 99);
         if (r < 65) gap = 0;
         else if (r < 88) gap = $urandom_range(1, 3);
         else if (r < 97) gap = $urandom_range(4, 12);
         else gap = $urandom_range(20, 60);
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_line();
      foreach (line_buf[k]) push_char(line_buf[k]);
   endtask

   task automatic send_text(input string s);
      for (int k = 0; k < s.len(); k++) push_char(s[k]);
   endtask

   // Hex digit with random letter case: the parser decodes 'a'..'f'
   // to the same values as 'A'..'F'.
   function automatic logic [CharWidth-1:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return ChZero + v;
      if ($urandom_range(0, 4) == 0) return ChLowerA + (v - 4'd10);
      return ChUpperA + (v - 4'd10);
   endfunction

   task automatic add_byte(input logic [7:0] b);
      line_buf.push_back(hex_char(b[7:4]));
      line_buf.push_back(hex_char(b[3:0]));
   endtask

   // Build a full record text into line_buf. Data bytes come from data_buf
   // while it lasts, random after that.
   task automatic build_record(input logic [7:0] count, input logic [15:0] offs,
                               input logic [7:0] kind_byte, input bit good_sum);
      logic [7:0] sum;
      logic [7:0] b;
      line_buf.delete();
      line_buf.push_back(ColonChar);
      sum = count + offs[15:8] + offs[7:0] + kind_byte;
      add_byte(count);
      add_byte(offs[15:8]);
      add_byte(offs[7:0]);
      add_byte(kind_byte);
      for (int k = 0; k < count; k++) begin
         b = (k < data_buf.size()) ? data_buf[k] : 8'($urandom_range(0, 255));
         sum = sum + b;
         add_byte(b);
      end
      sum = -sum;
      if (!good_sum) sum = sum ^ 8'($urandom_range(1, 255));
      add_byte(sum);
   endtask

   // Hold off the sender until every predicted word has come back, then
   // give the block time to finish a character that makes no word.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (chk_open != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_upper(input logic [UpperWidth-1:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly well-formed records with random content; the rest get a bad
   // checksum, a clobbered character, a cut-off tail or noise in front.
   task automatic random_record();
      int unsigned r;
      int unsigned n;
      int unsigned cut;
      logic [7:0] t;
      logic [15:0] offs;
      r = $urandom_range(0, 99);
      if (r < 80) n = $urandom_range(0, 8);
      else if (r < 97) n = $urandom_range(9, 24);
      else n = $urandom_range(25, 64);
      r = $urandom_range(0, 99);
      if (r < 70) t = DataRecord;
      else if (r < 80) t = EofRecord;
      else if (r < 90) t = 8'($urandom_range(2, 5));
      else t = 8'($urandom_range(0, 255));
      offs = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 99) < 15) offs[15:8] = 8'hFF;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         repeat ($urandom_range(1, 4)) push_char(8'($urandom_range(0, 255)));
      end
      data_buf.delete();
      build_record(n[7:0], offs, t, $urandom_range(0, 99) >= 15);
      r = $urandom_range(0, 99);
      if (r < 8) begin
         line_buf[$urandom_range(1, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (r < 15) begin
         cut = $urandom_range(1, line_buf.size() - 1);
         while (line_buf.size() > cut) void'(line_buf.pop_back());
      end
      send_line();
   endtask

   task automatic run_records(input int unsigned budget);
      int unsigned start;
      start = chars_sent;
      while (chars_sent - start < budget) begin
         random_record();
         // now and then let the whole pipe run dry
         if ($urandom_range(0, 99) < 3) wait_idle();
      end
   endtask

   // Hand-picked records under the reset upper address.
   task automatic directed_cases();
      // junk outside a record is dropped
      send_text("Z\r\n");
      push_char(8'h00);
      push_char(8'hFF);
      push_char(8'h80);
      // plain data record, extreme byte values
      data_buf = '{8'h00, 8'hFF, 8'h80, 8'h7F};
      build_record(8'd4, 16'h0000, DataRecord, 1'b1);
      send_line();
      // odd byte count: the last byte only counts in the checksum
      data_buf = '{8'hAA, 8'hBB, 8'hCC};
      build_record(8'd3, 16'h1234, DataRecord, 1'b1);
      send_line();
      data_buf.delete();
      // broken checksum
      build_record(8'd2, 16'hFFFE, DataRecord, 1'b0);
      send_line();
      // type high digit set, low digit still says data
      build_record(8'd2, 16'h0100, 8'h10, 1'b1);
      send_line();
      // non-data type: no writes, end word still comes
      build_record(8'd2, 16'h0200, 8'hF3, 1'b1);
      send_line();
      build_record(8'd0, 16'h0000, EofRecord, 1'b1);
      send_line();
      // a colon mid-record drops the partial one
      send_text(":0400");
      build_record(8'd2, 16'h0ABC, DataRecord, 1'b1);
      send_line();
      // characters outside 0-9/A-F decode without complaint
      send_text(":02000000Gz");
      push_char(8'hFF);
      push_char(8'h80);
      send_text("~!\n");
   endtask

   // Receiver: random stalls, mostly short. One long hold-off when asked,
   // and no stalls at all while the calm knob is up.
   initial begin : rsp_stall_gen
      int unsigned r;
      int unsigned len;
      bit held_off;
      held_off = 1'b0;
      forever begin
         if (rsp_hold_ask && !held_off) begin
            held_off = 1'b1;
            rsp_stall <= 1'b1;
            len = 400;
         end else if (calm) begin
            rsp_stall <= 1'b0;
            len = 1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
               rsp_stall <= 1'b0;
               len = $urandom_range(1, 20);
            end else if (r < 50) begin
               rsp_stall <= 1'b0;
               len = $urandom_range(30, 80);
            end else if (r < 85) begin
               rsp_stall <= 1'b1;
               len = $urandom_range(1, 3);
            end else if (r < 97) begin
               rsp_stall <= 1'b1;
               len = $urandom_range(4, 12);
            end else begin
               rsp_stall <= 1'b1;
               len = $urandom_range(20, 80);
            end
         end
         repeat (len) @(posedge clock);
      end
   end

   initial begin : stimulus
      int unsigned spin;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      directed_cases();
      wait_idle();

      write_upper(16'h0000);
      run_records(PhaseBudget);
      wait_idle();

      // top of the address map: the address sum wraps past 2^32
      write_upper(16'hFFFF);
      build_record(8'h20, 16'hFFF0, DataRecord, 1'b1);
      send_line();
      build_record(8'hFF, 16'hFF80, DataRecord, 1'b1);
      send_line();
      // receiver goes deaf while the sender keeps offering words
      rsp_hold_ask <= 1'b1;
      run_records(PhaseBudget);
      wait_idle();

      // stretch with no idling on either side
      write_upper(16'($urandom_range(0, 65535)));
      calm <= 1'b1;
      run_records(PhaseBudget - 50);
      wait_idle();
      calm <= 1'b0;

      write_upper(16'($urandom_range(0, 65535)));
      run_records(PhaseBudget);
      wait_idle();

      write_upper(16'h8001);
      run_records(PhaseBudget);

      req_valid <= 1'b0;
      spin = 0;
      do begin
         @(posedge clock);
         spin++;
      end while (chk_open != 0 && spin < 50000);
      repeat (8) @(posedge clock);

      if (chk_fails == 0 && chk_open == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin : watchdog
      #(16_000_000);
      $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/ihex_pkg.sv
rtl/ihex_parse.sv
rtl/ihex_rsp_fifo.sv
rtl/intel_hex_record_parser_top.sv
sim/ihex_record_checker.sv
sim/tb_top.sv
